FILE: hdl/clx_pkg.sv
// shared types, token class codes and the keyword rom for the lexer
// used by clx_front, clx_fifo, clx_back and c_lexer_with_symbol_table
package clx_pkg;

  localparam int SymbolDepthDef  = 64;
  localparam int LexemeCharsDef  = 8;
  localparam int KeywordCountDef = 24;
  localparam int KwRomDepth      = 32;
  localparam int QueueDepth      = 4;

  localparam logic [3:0] CLS_KEYWORD  = 4'd0;
  localparam logic [3:0] CLS_IDENT    = 4'd1;
  localparam logic [3:0] CLS_NUMBER   = 4'd2;
  localparam logic [3:0] CLS_RELOP    = 4'd3;
  localparam logic [3:0] CLS_DELIM    = 4'd4;
  localparam logic [3:0] CLS_OPER     = 4'd5;
  localparam logic [3:0] CLS_FMT      = 4'd6;
  localparam logic [3:0] CLS_UNKNOWN  = 4'd7;
  localparam logic [3:0] CLS_INVALID  = 4'd8;
  localparam logic [3:0] CLS_OPEN_CMT = 4'd9;

  // lexeme handed from the scanner to the lookup side
  typedef struct packed {
    logic [3:0]  cls;
    logic [63:0] text;
    logic [3:0]  len;
    logic        trunc;
    logic        last;
  } tok_t;

  // one finished result
  typedef struct packed {
    logic        last;
    logic        full;
    logic        added;
    logic [5:0]  slot;
    logic [4:0]  kw;
    logic        trunc;
    logic [3:0]  len;
    logic [63:0] text;
    logic [3:0]  cls;
  } res_t;

  // keyword text, first character in the high byte, and its length
  function automatic void kw_raw(input logic [4:0] idx, output logic [63:0] lit,
                                 output logic [3:0] len);
    begin
      lit = '0;
      len = 4'd0;
      case (idx)
        5'd0:  begin lit = 64'("int");      len = 4'd3; end
        5'd1:  begin lit = 64'("while");    len = 4'd5; end
        5'd2:  begin lit = 64'("break");    len = 4'd5; end
        5'd3:  begin lit = 64'("for");      len = 4'd3; end
        5'd4:  begin lit = 64'("do");       len = 4'd2; end
        5'd5:  begin lit = 64'("if");       len = 4'd2; end
        5'd6:  begin lit = 64'("float");    len = 4'd5; end
        5'd7:  begin lit = 64'("char");     len = 4'd4; end
        5'd8:  begin lit = 64'("switch");   len = 4'd6; end
        5'd9:  begin lit = 64'("double");   len = 4'd6; end
        5'd10: begin lit = 64'("short");    len = 4'd5; end
        5'd11: begin lit = 64'("long");     len = 4'd4; end
        5'd12: begin lit = 64'("unsigned"); len = 4'd8; end
        5'd13: begin lit = 64'("sizeof");   len = 4'd6; end
        5'd14: begin lit = 64'("else");     len = 4'd4; end
        5'd15: begin lit = 64'("register"); len = 4'd8; end
        5'd16: begin lit = 64'("extern");   len = 4'd6; end
        5'd17: begin lit = 64'("static");   len = 4'd6; end
        5'd18: begin lit = 64'("auto");     len = 4'd4; end
        5'd19: begin lit = 64'("case");     len = 4'd4; end
        5'd20: begin lit = 64'("break");    len = 4'd5; end
        5'd21: begin lit = 64'("volatile"); len = 4'd8; end
        5'd22: begin lit = 64'("enum");     len = 4'd4; end
        5'd23: begin lit = 64'("typedef");  len = 4'd7; end
        default: begin lit = '0; len = 4'd0; end
      endcase
    end
  endfunction

  // keyword text with the first character in the low byte
  function automatic logic [63:0] kw_word(input logic [4:0] idx);
    logic [63:0] lit;
    logic [3:0]  len;
    logic [63:0] w;
    begin
      kw_raw(idx, lit, len);
      w = '0;
      for (int k = 0; k < 8; k++) begin
        if (k < int'(len)) w[8*k +: 8] = lit[8*(int'(len) - 1 - k) +: 8];
      end
      return w;
    end
  endfunction

  function automatic logic [3:0] kw_len(input logic [4:0] idx);
    logic [63:0] lit;
    logic [3:0]  len;
    begin
      kw_raw(idx, lit, len);
      return len;
    end
  endfunction

endpackage

FILE: hdl/c_lexer_with_symbol_table.sv
// top level of the lexer: scanner front, token queue, lookup back
// depends on clx_pkg, clx_front, clx_fifo, clx_back
//
//  channel | ports        | tdata / tuser
//  input   | in_t*        | tdata: char_code[7:0]; tuser: kind
//  result  | out_t*       | tdata: class, text, length, truncated, keyword,
//          |              |        slot, added, full; tlast: last_result
//
// a byte is taken when both pending token slots of the scanner are empty;
// the slots drain into the token queue while it has room.
// an identifier is searched in the lookup side: one entry of the symbol
// memory is read per cycle through its single read port. reset is
// synchronous and active low and empties the symbol table; either side may
// stall without loss.
module c_lexer_with_symbol_table #(
  parameter int SYMBOL_DEPTH  = clx_pkg::SymbolDepthDef,
  parameter int LEXEME_CHARS  = clx_pkg::LexemeCharsDef,
  parameter int KEYWORD_COUNT = clx_pkg::KeywordCountDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // char_code[7:0]
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  // token_class[3:0], lexeme_text[67:4], lexeme_length[71:68],
  // lexeme_truncated[72], keyword_number[77:73], symbol_slot[83:78],
  // symbol_added[84], table_full[85], zero pad[87:86]
  output logic [87:0] out_tdata,
  output logic        out_tlast
);
  import clx_pkg::*;

  logic push, q_full, q_pop, q_empty;
  tok_t push_tok, q_tok;
  res_t res;

  clx_front #(.LEXEME_CHARS(LEXEME_CHARS)) u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .in_kind(in_tuser),
    .in_char(in_tdata), .push, .push_tok, .q_full
  );

  clx_fifo u_fifo (
    .clk, .rst_n, .push, .push_tok, .full(q_full), .pop(q_pop), .pop_tok(q_tok),
    .empty(q_empty)
  );

  clx_back #(.SYMBOL_DEPTH(SYMBOL_DEPTH), .KEYWORD_COUNT(KEYWORD_COUNT)) u_back (
    .clk, .rst_n, .q_empty, .q_tok, .q_pop, .out_valid(out_tvalid),
    .out_ready(out_tready), .out_res(res)
  );

  // pack the result beat
  assign out_tdata = {2'b00, res.full, res.added, res.slot, res.kw, res.trunc, res.len,
                      res.text, res.cls};
  assign out_tlast = res.last;

endmodule

FILE: hdl/clx_front.sv
// scanner: takes source bytes, tracks the lexeme and emits up to two tokens
// per beat into the token queue; depends on clx_pkg
module clx_front #(
  parameter int LEXEME_CHARS = clx_pkg::LexemeCharsDef
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           in_kind,
  input  logic [7:0]     in_char,
  output logic           push,
  output clx_pkg::tok_t  push_tok,
  input  logic           q_full
);
  import clx_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_IDENT, S_NUMBER, S_RELOP, S_SLASH, S_COMMENT, S_CSTAR, S_OPFMT
  } scan_t;

  scan_t       st_r, st_nxt;
  logic [63:0] buf_r, buf_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        ovf_r, ovf_nxt;
  tok_t        p0_r, p0_nxt, p1_r, p1_nxt;
  logic        p0v_r, p0v_nxt, p1v_r, p1v_nxt;

  logic        acc, alpha, digit;
  logic [63:0] ap_buf;
  logic [3:0]  ap_cnt;
  logic        ap_ovf;
  tok_t        fl_tok, fa_tok, id_tok, ta, tb;
  logic        fl_v, fa_v, id_v, ta_v, tb_v;
  scan_t       id_st;
  logic [63:0] id_buf;
  logic [3:0]  id_cnt;

  // token for the lexeme pending in a given scanner state
  function automatic void flush_tok(input scan_t st, input logic [63:0] b,
                                    input logic [3:0] n, input logic o,
                                    output tok_t t, output logic v);
    begin
      t = '{cls: CLS_NUMBER, text: b, len: n, trunc: o, last: 1'b0};
      v = 1'b1;
      case (st)
        S_IDENT:  t.cls = CLS_IDENT;
        S_NUMBER: t.cls = CLS_NUMBER;
        S_RELOP:  t.cls = CLS_RELOP;
        S_OPFMT:  t.cls = CLS_OPER;
        S_SLASH:  t = '{cls: CLS_INVALID, text: 64'h2f, len: 4'd1, trunc: 1'b0,
                        last: 1'b0};
        S_COMMENT, S_CSTAR:
          t = '{cls: CLS_OPEN_CMT, text: '0, len: 4'd0, trunc: 1'b0, last: 1'b0};
        default:  v = 1'b0;
      endcase
    end
  endfunction

  assign acc      = in_valid && in_ready;
  assign in_ready = !p0v_r && !p1v_r;
  assign alpha    = ((in_char | 8'h20) >= 8'h61) && ((in_char | 8'h20) <= 8'h7a);
  assign digit    = (in_char >= 8'h30) && (in_char <= 8'h39);

  // append the byte to the current lexeme
  always_comb begin
    ap_buf = buf_r;
    ap_cnt = cnt_r;
    ap_ovf = ovf_r;
    if (int'(cnt_r) < LEXEME_CHARS) begin
      for (int k = 0; k < 8; k++) begin
        if (k == int'(cnt_r)) ap_buf[8*k +: 8] = in_char;
      end
      ap_cnt = cnt_r + 4'd1;
    end else begin
      ap_ovf = 1'b1;
    end
  end

  // classify the byte as a fresh start from idle
  always_comb begin
    id_st  = S_IDLE;
    id_buf = {56'd0, in_char};
    id_cnt = 4'd1;
    id_v   = 1'b0;
    id_tok = '{cls: CLS_UNKNOWN, text: {56'd0, in_char}, len: 4'd1, trunc: 1'b0,
               last: 1'b0};
    if (alpha) begin
      id_st = S_IDENT;
    end else if (digit) begin
      id_st = S_NUMBER;
    end else begin
      case (in_char)
        8'h21, 8'h3d, 8'h3c, 8'h3e: id_st = S_RELOP;
        8'h2f: begin
          id_st  = S_SLASH;
          id_buf = '0;
          id_cnt = 4'd0;
        end
        8'h20, 8'h09, 8'h0a: begin
          id_buf = '0;
          id_cnt = 4'd0;
        end
        8'h28, 8'h29, 8'h2c, 8'h7b, 8'h7d, 8'h3b, 8'h22: begin
          id_v       = 1'b1;
          id_tok.cls = CLS_DELIM;
          id_buf     = '0;
          id_cnt     = 4'd0;
        end
        8'h25, 8'h2b, 8'h2d, 8'h2a, 8'h26: id_st = S_OPFMT;
        default: begin
          id_v   = 1'b1;
          id_buf = '0;
          id_cnt = 4'd0;
        end
      endcase
    end
  end

  // scanner step: up to two tokens in order
  always_comb begin
    flush_tok(st_r, buf_r, cnt_r, ovf_r, fl_tok, fl_v);
    flush_tok(st_r, ap_buf, ap_cnt, ap_ovf, fa_tok, fa_v);
    st_nxt  = st_r;
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    ta = fl_tok;
    ta_v = 1'b0;
    tb = id_tok;
    tb_v = 1'b0;
    if (in_kind) begin
      ta_v = fl_v;
      st_nxt = S_IDLE;
      buf_nxt = '0;
      cnt_nxt = 4'd0;
      ovf_nxt = 1'b0;
    end else begin
      // default path: pending lexeme out, byte rescanned from idle
      ta_v    = fl_v;
      tb_v    = id_v;
      st_nxt  = id_st;
      buf_nxt = id_buf;
      cnt_nxt = id_cnt;
      ovf_nxt = 1'b0;
      case (st_r)
        S_IDENT: begin
          if (alpha || digit) begin
            ta_v = 1'b0; tb_v = 1'b0;
            st_nxt = st_r; buf_nxt = ap_buf; cnt_nxt = ap_cnt; ovf_nxt = ap_ovf;
          end
        end
        S_NUMBER: begin
          if (digit || in_char == 8'h2e) begin
            ta_v = 1'b0; tb_v = 1'b0;
            st_nxt = st_r; buf_nxt = ap_buf; cnt_nxt = ap_cnt; ovf_nxt = ap_ovf;
          end
        end
        S_RELOP: begin
          if (in_char == 8'h3d) begin
            ta = fa_tok; ta_v = fa_v; tb_v = 1'b0;
            st_nxt = S_IDLE; buf_nxt = '0; cnt_nxt = 4'd0;
          end
        end
        S_SLASH: begin
          if (in_char == 8'h2a) begin
            ta_v = 1'b0; tb_v = 1'b0; st_nxt = S_COMMENT;
          end
        end
        S_COMMENT: begin
          ta_v = 1'b0; tb_v = 1'b0;
          st_nxt = (in_char == 8'h2a) ? S_CSTAR : S_COMMENT;
        end
        S_CSTAR: begin
          ta_v = 1'b0; tb_v = 1'b0;
          if (in_char == 8'h2a) st_nxt = S_CSTAR;
          else if (in_char == 8'h2f) st_nxt = S_IDLE;
          else st_nxt = S_COMMENT;
        end
        S_OPFMT: begin
          if (in_char == 8'h64 || in_char == 8'h66) begin
            ta = fa_tok; ta.cls = CLS_FMT; ta_v = fa_v; tb_v = 1'b0;
            st_nxt = S_IDLE; buf_nxt = '0; cnt_nxt = 4'd0;
          end
        end
        default: ;
      endcase
    end
  end

  // pending token slots, drained one a cycle into the queue while it is not full
  always_comb begin
    p0_nxt  = p0_r;
    p1_nxt  = p1_r;
    p0v_nxt = p0v_r;
    p1v_nxt = p1v_r;
    if (acc) begin
      if (ta_v) begin
        p0_nxt = ta; p0_nxt.last = !tb_v;
        p1_nxt = tb; p1_nxt.last = 1'b1;
        p0v_nxt = 1'b1; p1v_nxt = tb_v;
      end else begin
        p0_nxt = tb; p0_nxt.last = 1'b1;
        p0v_nxt = tb_v; p1v_nxt = 1'b0;
      end
    end else if (p0v_r && !q_full) begin
      p0_nxt  = p1_r;
      p0v_nxt = p1v_r;
      p1v_nxt = 1'b0;
    end
  end

  assign push     = p0v_r && !q_full;
  assign push_tok = p0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      buf_r <= '0;
      cnt_r <= 4'd0;
      ovf_r <= 1'b0;
      p0v_r <= 1'b0;
      p1v_r <= 1'b0;
    end else begin
      if (acc) begin
        st_r  <= st_nxt;
        buf_r <= buf_nxt;
        cnt_r <= cnt_nxt;
        ovf_r <= ovf_nxt;
      end
      p0v_r <= p0v_nxt;
      p1v_r <= p1v_nxt;
    end
    p0_r <= p0_nxt;
    p1_r <= p1_nxt;
  end

endmodule

FILE: hdl/clx_fifo.sv
// short token queue between scanner and lookup side
// depends on clx_pkg for the token type and depth
module clx_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  clx_pkg::tok_t push_tok,
  output logic          full,
  input  logic          pop,
  output clx_pkg::tok_t pop_tok,
  output logic          empty
);
  import clx_pkg::*;

  localparam int PW = $clog2(QueueDepth);

  tok_t          mem_r [QueueDepth];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;

  assign full    = (cnt_r == (PW+1)'(QueueDepth));
  assign empty   = (cnt_r == '0);
  assign pop_tok = mem_r[rp_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
    if (push) mem_r[wp_r] <= push_tok;
  end

endmodule

FILE: hdl/clx_back.sv
// lookup side: keyword match, symbol table search and insert, result register
// depends on clx_pkg
module clx_back #(
  parameter int SYMBOL_DEPTH  = clx_pkg::SymbolDepthDef,
  parameter int KEYWORD_COUNT = clx_pkg::KeywordCountDef
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  clx_pkg::tok_t q_tok,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output clx_pkg::res_t out_res
);
  import clx_pkg::*;

  localparam int AW = (SYMBOL_DEPTH > 1) ? $clog2(SYMBOL_DEPTH) : 1;
  localparam int CW = $clog2(SYMBOL_DEPTH + 1);

  typedef enum logic [1:0] {B_IDLE, B_KW, B_SRCH, B_EMIT} bst_t;

  bst_t          st_r;
  tok_t          tok_r;
  res_t          res_r, ores_r;
  logic          ov_r;
  logic [63:0]   sym_mem [SYMBOL_DEPTH];
  logic [63:0]   rdata_r;
  logic [CW-1:0] scnt_r, j_r, cidx_r;
  logic          cvld_r;
  logic          kw_hit;
  logic [4:0]    kw_idx;
  logic          out_free;

  assign out_free  = !ov_r || out_ready;
  assign q_pop     = (st_r == B_IDLE) && !q_empty;
  assign out_valid = ov_r;
  assign out_res   = ores_r;

  // first keyword in the rom that equals the lexeme
  always_comb begin
    kw_hit = 1'b0;
    kw_idx = 5'd0;
    for (int i = KwRomDepth - 1; i >= 0; i--) begin
      if (i < KEYWORD_COUNT && kw_len(5'(i)) != 4'd0 && kw_len(5'(i)) == tok_r.len
          && kw_word(5'(i)) == tok_r.text) begin
        kw_hit = 1'b1;
        kw_idx = 5'(i);
      end
    end
  end

  // symbol memory, one read and one write port
  always_ff @(posedge clk) begin
    rdata_r <= sym_mem[j_r[AW-1:0]];
    if (st_r == B_SRCH && !(cvld_r && rdata_r == tok_r.text) && j_r >= scnt_r
        && !cvld_r && scnt_r < CW'(SYMBOL_DEPTH))
      sym_mem[scnt_r[AW-1:0]] <= tok_r.text;
  end

  // lookup sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= B_IDLE;
      ov_r   <= 1'b0;
      scnt_r <= '0;
      cvld_r <= 1'b0;
      j_r    <= '0;
    end else begin
      if (st_r == B_EMIT && out_free) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      case (st_r)
        B_IDLE: begin
          if (!q_empty) begin
            tok_r <= q_tok;
            res_r <= '{last: q_tok.last, full: 1'b0, added: 1'b0, slot: '0,
                       kw: '0, trunc: q_tok.trunc, len: q_tok.len,
                       text: q_tok.text, cls: q_tok.cls};
            st_r  <= (q_tok.cls == CLS_IDENT) ? B_KW : B_EMIT;
          end
        end
        B_KW: begin
          j_r    <= '0;
          cvld_r <= 1'b0;
          if (!tok_r.trunc && kw_hit) begin
            res_r.cls <= CLS_KEYWORD;
            res_r.kw  <= kw_idx;
            st_r      <= B_EMIT;
          end else begin
            st_r <= B_SRCH;
          end
        end
        B_SRCH: begin
          if (cvld_r && rdata_r == tok_r.text) begin
            res_r.slot <= 6'(cidx_r);
            st_r       <= B_EMIT;
          end else if (j_r < scnt_r) begin
            cvld_r <= 1'b1;
            cidx_r <= j_r;
            j_r    <= j_r + 1'b1;
          end else if (cvld_r) begin
            cvld_r <= 1'b0;
          end else begin
            if (scnt_r < CW'(SYMBOL_DEPTH)) begin
              res_r.slot  <= 6'(scnt_r);
              res_r.added <= 1'b1;
              scnt_r      <= scnt_r + 1'b1;
            end else begin
              res_r.full <= 1'b1;
            end
            st_r <= B_EMIT;
          end
        end
        B_EMIT: begin
          if (out_free) begin
            ores_r <= res_r;
            st_r   <= B_IDLE;
          end
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end

endmodule
